// File: src/rdss_pkg.sv
// Package for the ROM date string scanner: beat types, date record and position test.
`default_nettype none

package rdss_pkg;

    localparam int WinLen  = 10;
    localparam int ExtLen  = WinLen + 2;
    localparam int SeenW   = 4;
    localparam int FieldW  = 6;

    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChTwo   = 8'h32;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [3:0] YearSplitTens = 4'd8;
    localparam logic [1:0] AsciiDigitTop = 2'b11;

    localparam logic [SeenW-1:0] SeenMax = SeenW'(WinLen);

    typedef struct packed {
        logic [7:0] rom_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic              date_found;
        logic [FieldW-1:0] month_tens;
        logic [FieldW-1:0] month_units;
        logic [FieldW-1:0] day_tens;
        logic [FieldW-1:0] day_units;
        logic [FieldW-1:0] year_tens;
        logic [FieldW-1:0] year_units;
        logic [FieldW-1:0] century_tens;
        logic [FieldW-1:0] century_units;
    } t_out_beat;

    // Decimal digits, most significant first, so the packed value orders dates.
    typedef struct packed {
        logic [3:0] century_t;
        logic [3:0] century_u;
        logic [3:0] year_t;
        logic [3:0] year_u;
        logic [3:0] month_t;
        logic [3:0] month_u;
        logic [3:0] day_t;
        logic [3:0] day_u;
    } t_date;

    typedef struct packed {
        logic  hit;
        t_date date;
    } t_pos_res;

    // Ten bytes around one slash position: index 2 is the slash itself.
    typedef logic [WinLen-1:0][7:0] t_span;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= ChZero) && (c <= ChNine);
    endfunction

    function automatic t_pos_res eval_pos(input t_span s, input logic four_mode);
        t_pos_res r;
        logic     long_year;
        r.hit = (s[2] == ChSlash) && (s[5] == ChSlash) && is_dig(s[1]) && is_dig(s[3])
              && is_dig(s[4]) && is_dig(s[6]) && is_dig(s[7]);
        r.date.month_t = is_dig(s[0]) ? s[0][3:0] : 4'd0;
        r.date.month_u = s[1][3:0];
        r.date.day_t   = s[3][3:0];
        r.date.day_u   = s[4][3:0];
        long_year = four_mode && is_dig(s[8]) && is_dig(s[9])
                  && (((s[6] == ChOne) && (s[7] == ChNine))
                   || ((s[6] == ChTwo) && (s[7] == ChZero)));
        if (long_year) begin
            r.date.century_t = s[6][3:0];
            r.date.century_u = s[7][3:0];
            r.date.year_t    = s[8][3:0];
            r.date.year_u    = s[9][3:0];
        end else begin
            r.date.year_t = s[6][3:0];
            r.date.year_u = s[7][3:0];
            if (s[6][3:0] < YearSplitTens) begin
                r.date.century_t = ChTwo[3:0];
                r.date.century_u = ChZero[3:0];
            end else begin
                r.date.century_t = ChOne[3:0];
                r.date.century_u = ChNine[3:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/rom_date_string_scanner_top.sv
// Top level of the ROM date string scanner: input register, window scan and result register.
// A result beat is loaded into the result register as the last byte of an image leaves the
// input register. Throughput: one byte per cycle while no result stalls; the window test and the
// end-of-image flush of the two pending slash positions are combinational on the input register.
// Reset clears the window, counters, best date and both beat valid flags; the year mode
// register resets to 1. A stalled result holds back the next image's last byte and later input.
`default_nettype none

module rom_date_string_scanner_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire rdss_pkg::t_in_beat i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output rdss_pkg::t_out_beat   o_out_data,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_wdata
);
    import rdss_pkg::*;

    localparam int NPos = 3;

    logic                   r_mode;
    logic                   r_s1_valid;
    t_in_beat               r_s1;
    logic [WinLen-1:0][7:0] r_win;
    logic [WinLen-1:0][7:0] n_win;
    logic [SeenW-1:0]       r_seen;
    logic [SeenW-1:0]       n_seen;
    logic [1:0]             r_skip;
    logic [1:0]             n_skip;
    t_date                  r_best;
    t_date                  n_best;
    logic                   r_best_valid;
    logic                   n_best_valid;
    logic                   r_out_valid;
    t_out_beat              r_out;
    t_out_beat              n_out;

    logic [ExtLen-1:0][7:0] ext;
    t_pos_res               pos_res [NPos];
    logic [NPos-1:0]        pos_en;
    logic                   in_accept;
    logic                   out_free;
    logic                   s1_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (!r_s1.last_byte || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign n_win  = {r_s1.rom_byte, r_win[WinLen-1:1]};
    assign n_seen = (r_seen < SeenMax) ? r_seen + 1'b1 : r_seen;
    // Bytes beyond the end of the image read as zero.
    assign ext    = {16'h0000, n_win};

    // Slash positions 2, 3 and 4 of the extended window; the last two only at image end.
    for (genvar g = 0; g < NPos; g++) begin : g_pos
        assign pos_res[g] = eval_pos(ext[g + 9:g], r_mode);
        assign pos_en[g]  = ((g == 0) || r_s1.last_byte)
                          && (({1'b0, n_seen} + 5'(g + 2)) >= 5'(ExtLen));
    end

    always_comb begin
        n_skip       = r_skip;
        n_best       = r_best;
        n_best_valid = r_best_valid;
        for (int i = 0; i < NPos; i++) begin
            if (pos_en[i]) begin
                if (n_skip != 2'd0) begin
                    n_skip = n_skip - 2'd1;
                end else if (pos_res[i].hit) begin
                    if (!n_best_valid || (n_best < pos_res[i].date)) begin
                        n_best = pos_res[i].date;
                    end
                    n_best_valid = 1'b1;
                    n_skip       = 2'd2;
                end
            end
        end
    end

    always_comb begin
        n_out.date_found = n_best_valid;
        if (n_best_valid) begin
            n_out.month_tens    = {AsciiDigitTop, n_best.month_t};
            n_out.month_units   = {AsciiDigitTop, n_best.month_u};
            n_out.day_tens      = {AsciiDigitTop, n_best.day_t};
            n_out.day_units     = {AsciiDigitTop, n_best.day_u};
            n_out.year_tens     = {AsciiDigitTop, n_best.year_t};
            n_out.year_units    = {AsciiDigitTop, n_best.year_u};
            n_out.century_tens  = {AsciiDigitTop, n_best.century_t};
            n_out.century_units = {AsciiDigitTop, n_best.century_u};
        end else begin
            n_out.month_tens    = '0;
            n_out.month_units   = '0;
            n_out.day_tens      = '0;
            n_out.day_units     = '0;
            n_out.year_tens     = '0;
            n_out.year_units    = '0;
            n_out.century_tens  = '0;
            n_out.century_units = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_seen       <= '0;
            r_skip       <= '0;
            r_best       <= '0;
            r_best_valid <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1.last_byte) begin
                r_win        <= '0;
                r_seen       <= '0;
                r_skip       <= '0;
                r_best       <= '0;
                r_best_valid <= 1'b0;
            end else begin
                r_win        <= n_win;
                r_seen       <= n_seen;
                r_skip       <= n_skip;
                r_best       <= n_best;
                r_best_valid <= n_best_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/rdss_checker.sv
// Port-level checker for the ROM date string scanner, with its bind to the top level.
`default_nettype none

module rdss_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_in_stall,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire rdss_pkg::t_out_beat o_out_data
);
    import rdss_pkg::*;

    // A result beat waiting on the consumer must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // No result beat can appear straight out of reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The input is only held back while a result beat waits on the consumer.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no waiting result");

    // Without a date every digit field is zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.date_found |->
            o_out_data.month_tens == '0 && o_out_data.month_units == '0
            && o_out_data.day_tens == '0 && o_out_data.day_units == '0
            && o_out_data.year_tens == '0 && o_out_data.year_units == '0
            && o_out_data.century_tens == '0 && o_out_data.century_units == '0)
        else $error("digits set without a date");

    // A found date always lies in the nineteen hundreds or the two thousands.
    a_century: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.date_found |->
            (o_out_data.century_tens == ChOne[FieldW-1:0]
                && o_out_data.century_units == ChNine[FieldW-1:0])
            || (o_out_data.century_tens == ChTwo[FieldW-1:0]
                && o_out_data.century_units == ChZero[FieldW-1:0]))
        else $error("century out of range");

endmodule

bind rom_date_string_scanner_top rdss_checker u_rdss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
